[hw/rtl/tpe_pkg.sv]
// Shared types, constants and rounding helpers for the trivariate polynomial evaluator.
package tpe_pkg;

   localparam int DEGREE_W = 4;
   localparam int COEF_W   = 32;
   localparam int COORD_W  = 16;
   localparam int PW_W     = 32;
   localparam int PROD_W   = 64;
   localparam int ACC_W    = 56;
   localparam int OUT_W    = 48;
   localparam int INDEX_W  = 9;
   localparam int CSR_AW   = 2;
   localparam int CSR_DW   = 32;

   localparam logic [0:0]        OP_LOAD         = 1'b0;
   localparam logic [0:0]        OP_EVAL         = 1'b1;
   localparam logic [CSR_AW-1:0] CSR_DEGREE_ADDR = 2'd0;

   localparam logic signed [PW_W-1:0]  ONE_Q30 = 32'sd1073741824;
   localparam logic signed [ACC_W-1:0] OUT_MAX = (56'sd1 <<< 47) - 56'sd1;
   localparam logic signed [ACC_W-1:0] OUT_MIN = -(56'sd1 <<< 47);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POWERS,
      ST_MAC,
      ST_DRAIN,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic coef_wr;
      logic start;
      logic pow_step;
      logic issue;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic pow_last;
      logic mac_last;
      logic pipe_busy;
   } dp_status_type;

   // round half up, then drop 15 fraction bits
   function automatic logic signed [PROD_W-1:0] rnd_q15(input logic signed [PROD_W-1:0] v);
      return (v + 64'sd16384) >>> 15;
   endfunction

   // round half up, then drop 30 fraction bits
   function automatic logic signed [PROD_W-1:0] rnd_q30(input logic signed [PROD_W-1:0] v);
      return (v + 64'sd536870912) >>> 30;
   endfunction

endpackage

[hw/rtl/tpe_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tpe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 286
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/tpe_ctrl.sv]
// Control state machine: sequences loads, power build-up, monomial issue and result hand-off.
module tpe_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_op,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  tpe_pkg::dp_status_type  status,
   output tpe_pkg::dp_cmd_type     cmd,
   output tpe_pkg::ctrl_state_type state
);

   tpe_pkg::ctrl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tpe_pkg::ST_IDLE: begin
            if (req_valid && (req_op == tpe_pkg::OP_EVAL)) state_in = tpe_pkg::ST_POWERS;
         end
         tpe_pkg::ST_POWERS: begin
            if (status.pow_last) state_in = tpe_pkg::ST_MAC;
         end
         tpe_pkg::ST_MAC: begin
            if (status.mac_last) state_in = tpe_pkg::ST_DRAIN;
         end
         tpe_pkg::ST_DRAIN: begin
            if (!status.pipe_busy) state_in = tpe_pkg::ST_DONE;
         end
         tpe_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = tpe_pkg::ST_IDLE;
         end
         default: state_in = tpe_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = (state_ff == tpe_pkg::ST_IDLE);
      cmd.coef_wr  = req_ready && req_valid && (req_op == tpe_pkg::OP_LOAD);
      cmd.start    = req_ready && req_valid && (req_op == tpe_pkg::OP_EVAL);
      cmd.pow_step = (state_ff == tpe_pkg::ST_POWERS);
      cmd.issue    = (state_ff == tpe_pkg::ST_MAC);
      cmd.out_load = (state_ff == tpe_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);
      // hold the result until taken, refill as soon as the slot frees
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tpe_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign state     = state_ff;

endmodule

[hw/rtl/tpe_datapath.sv]
// Datapath: coefficient RAM, power tables, monomial index walk and multiply-accumulate pipeline.
module tpe_datapath #(
   parameter int MAX_DEGREE = 10,
   parameter int NUM_COEFFS = 286
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tpe_pkg::dp_cmd_type                 cmd,
   output tpe_pkg::dp_status_type              status,
   input  logic [tpe_pkg::DEGREE_W-1:0]        degree,
   input  logic [tpe_pkg::INDEX_W-1:0]         coeff_index,
   input  logic signed [tpe_pkg::COEF_W-1:0]   coeff_value,
   input  logic signed [tpe_pkg::COORD_W-1:0]  x_coord,
   input  logic signed [tpe_pkg::COORD_W-1:0]  y_coord,
   input  logic signed [tpe_pkg::COORD_W-1:0]  z_coord,
   output logic signed [tpe_pkg::OUT_W-1:0]    poly_value,
   output logic                                saturated
);

   localparam int AW = $clog2(NUM_COEFFS);
   localparam int DW = $clog2(MAX_DEGREE + 1);

   // ---- power tables ----
   logic signed [tpe_pkg::COORD_W-1:0] x_ff, y_ff, z_ff;
   logic signed [tpe_pkg::PW_W-1:0]    px_ff [MAX_DEGREE+1];
   logic signed [tpe_pkg::PW_W-1:0]    py_ff [MAX_DEGREE+1];
   logic signed [tpe_pkg::PW_W-1:0]    pz_ff [MAX_DEGREE+1];
   logic [DW-1:0]                      k_ff, k_in, km1;
   logic signed [tpe_pkg::PROD_W-1:0]  px_prod, py_prod, pz_prod;
   logic signed [tpe_pkg::PW_W-1:0]    px_step_in, py_step_in, pz_step_in;

   assign km1     = k_ff - DW'(1);
   assign px_prod = tpe_pkg::PROD_W'(px_ff[km1]) * tpe_pkg::PROD_W'(x_ff);
   assign py_prod = tpe_pkg::PROD_W'(py_ff[km1]) * tpe_pkg::PROD_W'(y_ff);
   assign pz_prod = tpe_pkg::PROD_W'(pz_ff[km1]) * tpe_pkg::PROD_W'(z_ff);
   assign px_step_in = tpe_pkg::PW_W'(tpe_pkg::rnd_q15(px_prod));
   assign py_step_in = tpe_pkg::PW_W'(tpe_pkg::rnd_q15(py_prod));
   assign pz_step_in = tpe_pkg::PW_W'(tpe_pkg::rnd_q15(pz_prod));
   assign k_in = cmd.start ? DW'(1) : (cmd.pow_step ? k_ff + DW'(1) : k_ff);

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      if (cmd.start) begin
         x_ff     <= x_coord;
         y_ff     <= y_coord;
         z_ff     <= z_coord;
         px_ff[0] <= tpe_pkg::ONE_Q30;
         py_ff[0] <= tpe_pkg::ONE_Q30;
         pz_ff[0] <= tpe_pkg::ONE_Q30;
      end
      if (cmd.pow_step) begin
         px_ff[k_ff] <= px_step_in;
         py_ff[k_ff] <= py_step_in;
         pz_ff[k_ff] <= pz_step_in;
      end
   end

   assign status.pow_last = (k_ff == DW'(MAX_DEGREE));

   // ---- monomial walk in graded lexicographic order ----
   logic [DW-1:0] d_ff, a_ff, b_ff, d_in, a_in, b_in, c_sel, top_deg;
   logic [AW-1:0] idx_ff, idx_in;

   assign top_deg = (degree > tpe_pkg::DEGREE_W'(MAX_DEGREE)) ? DW'(MAX_DEGREE) : DW'(degree);
   assign c_sel   = d_ff - a_ff - b_ff;

   always_comb begin
      d_in   = d_ff;
      a_in   = a_ff;
      b_in   = b_ff;
      idx_in = idx_ff;
      if (cmd.start) begin
         d_in   = '0;
         a_in   = '0;
         b_in   = '0;
         idx_in = '0;
      end else if (cmd.issue) begin
         idx_in = idx_ff + AW'(1);
         if (b_ff != '0) begin
            b_in = b_ff - DW'(1);
         end else if (a_ff != '0) begin
            a_in = a_ff - DW'(1);
            b_in = d_ff - a_ff + DW'(1);
         end else begin
            d_in = d_ff + DW'(1);
            a_in = d_ff + DW'(1);
            b_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      d_ff   <= d_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      idx_ff <= idx_in;
   end

   assign status.mac_last = (idx_ff == AW'(NUM_COEFFS - 1)) ||
                            ((d_ff == top_deg) && (a_ff == '0) && (b_ff == '0));

   // ---- coefficient store ----
   logic [tpe_pkg::COEF_W-1:0] coef_rd;
   logic                       coef_we;

   assign coef_we = cmd.coef_wr && (coeff_index < tpe_pkg::INDEX_W'(NUM_COEFFS));

   tpe_ram #(
      .WIDTH(tpe_pkg::COEF_W),
      .DEPTH(NUM_COEFFS)
   ) u_coef_ram (
      .clock  (clock),
      .wr_en  (coef_we),
      .wr_addr(coeff_index[AW-1:0]),
      .wr_data(coeff_value),
      .rd_en  (cmd.issue),
      .rd_addr(idx_ff),
      .rd_data(coef_rd)
   );

   // ---- multiply-accumulate pipeline ----
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [tpe_pkg::PW_W-1:0]   pxa_ff, pyb_ff, pzc_ff, pzc2_ff, m1_ff, m2_ff;
   logic signed [tpe_pkg::COEF_W-1:0] coef2_ff, coef3_ff;
   logic signed [tpe_pkg::ACC_W-1:0]  term_ff, acc_ff, acc_in;
   logic signed [tpe_pkg::PROD_W-1:0] m1_prod, m2_prod, term_prod;

   assign m1_prod   = tpe_pkg::PROD_W'(pxa_ff) * tpe_pkg::PROD_W'(pyb_ff);
   assign m2_prod   = tpe_pkg::PROD_W'(m1_ff) * tpe_pkg::PROD_W'(pzc2_ff);
   assign term_prod = tpe_pkg::PROD_W'(coef3_ff) * tpe_pkg::PROD_W'(m2_ff);

   always_comb begin
      acc_in = acc_ff;
      if (cmd.start) begin
         acc_in = '0;
      end else if (v4_ff) begin
         acc_in = acc_ff + term_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      pxa_ff   <= px_ff[a_ff];
      pyb_ff   <= py_ff[b_ff];
      pzc_ff   <= pz_ff[c_sel];
      m1_ff    <= tpe_pkg::PW_W'(tpe_pkg::rnd_q30(m1_prod));
      pzc2_ff  <= pzc_ff;
      coef2_ff <= coef_rd;
      m2_ff    <= tpe_pkg::PW_W'(tpe_pkg::rnd_q30(m2_prod));
      coef3_ff <= coef2_ff;
      term_ff  <= tpe_pkg::ACC_W'(tpe_pkg::rnd_q30(term_prod));
      acc_ff   <= acc_in;
   end

   assign status.pipe_busy = v1_ff || v2_ff || v3_ff || v4_ff;

   // ---- saturate and hold the result ----
   logic signed [tpe_pkg::OUT_W-1:0] poly_ff;
   logic                             sat_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (acc_ff > tpe_pkg::OUT_MAX) begin
            poly_ff <= tpe_pkg::OUT_W'(tpe_pkg::OUT_MAX);
            sat_ff  <= 1'b1;
         end else if (acc_ff < tpe_pkg::OUT_MIN) begin
            poly_ff <= tpe_pkg::OUT_W'(tpe_pkg::OUT_MIN);
            sat_ff  <= 1'b1;
         end else begin
            poly_ff <= tpe_pkg::OUT_W'(acc_ff);
            sat_ff  <= 1'b0;
         end
      end
   end

   assign poly_value = poly_ff;
   assign saturated  = sat_ff;

endmodule

[hw/rtl/trivariate_polynomial_eval_unit.sv]
// Trivariate polynomial evaluator, top level: load items write coefficient words
// (taken whenever the unit is idle); an evaluate item builds the power tables
// up to MAX_DEGREE and then issues N monomials (N counts the monomials up to the
// programmed degree, 286 at degree 10) to the single multiply-accumulate pipeline,
// which reads one coefficient per cycle from the coefficient RAM. The RAM is not
// cleared at reset: write every slot that the programmed degree uses before
// evaluating. One result register sits on the output, so loads and a new
// evaluation proceed while a result waits to be taken.
module trivariate_polynomial_eval_unit #(
   parameter int MAX_DEGREE = 10,
   parameter int NUM_COEFFS = 286
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_op,
   input  logic [tpe_pkg::INDEX_W-1:0]         req_coeff_index,
   input  logic signed [tpe_pkg::COEF_W-1:0]   req_coeff_value,
   input  logic signed [tpe_pkg::COORD_W-1:0]  req_x_coord,
   input  logic signed [tpe_pkg::COORD_W-1:0]  req_y_coord,
   input  logic signed [tpe_pkg::COORD_W-1:0]  req_z_coord,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [tpe_pkg::OUT_W-1:0]    rsp_poly_value,
   output logic                                rsp_saturated,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tpe_pkg::CSR_AW-1:0]          paddr,
   input  logic [tpe_pkg::CSR_DW-1:0]          pwdata,
   output logic [tpe_pkg::CSR_DW-1:0]          prdata,
   output logic                                pready
);

   tpe_pkg::dp_cmd_type     cmd;
   tpe_pkg::dp_status_type  status;
   tpe_pkg::ctrl_state_type state;

   logic [tpe_pkg::DEGREE_W-1:0] degree_ff, degree_in;
   logic                         degree_hit;

   assign pready     = 1'b1;
   assign degree_hit = (paddr == tpe_pkg::CSR_DEGREE_ADDR);
   assign degree_in  = (psel && penable && pwrite && pready && degree_hit) ?
                       pwdata[tpe_pkg::DEGREE_W-1:0] : degree_ff;
   assign prdata     = degree_hit ? tpe_pkg::CSR_DW'(degree_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= '0;
      end else begin
         degree_ff <= degree_in;
      end
   end

   tpe_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_op   (req_op),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .status   (status),
      .cmd      (cmd),
      .state    (state)
   );

   tpe_datapath #(
      .MAX_DEGREE(MAX_DEGREE),
      .NUM_COEFFS(NUM_COEFFS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .degree     (degree_ff),
      .coeff_index(req_coeff_index),
      .coeff_value(req_coeff_value),
      .x_coord    (req_x_coord),
      .y_coord    (req_y_coord),
      .z_coord    (req_z_coord),
      .poly_value (rsp_poly_value),
      .saturated  (rsp_saturated)
   );

`ifndef ASSERT_OFF
   a_pipe_only_in_mac : assert property (@(posedge clock) disable iff (reset)
      status.pipe_busy |-> (state == tpe_pkg::ST_MAC || state == tpe_pkg::ST_DRAIN))
      else $error("multiply pipeline active outside evaluation");

   a_rsp_from_done : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid)) |-> ($past(state) == tpe_pkg::ST_DONE))
      else $error("result raised without a finished evaluation");

   a_done_after_drain : assert property (@(posedge clock) disable iff (reset)
      (state == tpe_pkg::ST_DONE) |-> !status.pipe_busy)
      else $error("result stage reached with items still in the pipeline");
`endif

endmodule
